// ===== hdl/script_token_scanner_core_defines.svh =====
// assertion macros shared by the scanner rtl
// no dependencies; taken in by files that carry concurrent checks
`ifndef SCRIPT_TOKEN_SCANNER_CORE_DEFINES_SVH
`define SCRIPT_TOKEN_SCANNER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is active
`define STSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scanner check failed");

// next-cycle implication, disabled while reset is active
`define STSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scanner check failed");

`endif

// ===== hdl/stsc_pkg.sv =====
// shared types, constants and keyword tables of the script token scanner
// no dependencies; imported by every scanner module
package stsc_pkg;

    localparam int DEFAULT_MAX_LEN       = 128;
    localparam int DEFAULT_POSITION_BITS = 16;
    localparam int QUEUE_DEPTH           = 4;
    localparam int KW_COUNT              = 9;

    typedef enum logic [2:0] {
        KIND_KEYWORD = 3'd0,
        KIND_IDENT   = 3'd1,
        KIND_STRING  = 3'd2,
        KIND_NUMBER  = 3'd3,
        KIND_SPECIAL = 3'd4,
        KIND_END     = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_IDENT  = 3'd1,
        MODE_NUMBER = 3'd2,
        MODE_STRING = 3'd3,
        MODE_SLASH  = 3'd4,
        MODE_LINE   = 3'd5,
        MODE_BLOCK  = 3'd6,
        MODE_STAR   = 3'd7
    } mode_t;

    // one token descriptor; word_len is the length when short enough to be a keyword, else 0
    typedef struct packed {
        kind_t       kind;
        logic [15:0] line;
        logic [15:0] column;
        logic [7:0]  length;
        logic [3:0]  word_len;
        logic        overflow;
        logic [7:0]  first;
        logic        closed;
        logic [63:0] prefix;
    } tok_t;

    // results of one input transfer, in order
    typedef struct packed {
        logic second_valid;
        tok_t second;
        tok_t first_tok;
    } entry_t;

    // keyword text, byte 0 in the low bits, zero padded
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'h6e6f6974636e7566,   // function
        64'h0000000000726176,   // var
        64'h000000000074656c,   // let
        64'h00000074736e6f63,   // const
        64'h0000000000006669,   // if
        64'h0000000065736c65,   // else
        64'h0000000000726f66,   // for
        64'h000000656c696877,   // while
        64'h00006e7275746572    // return
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd8, 4'd3, 4'd3, 4'd5, 4'd2, 4'd4, 4'd3, 4'd5, 4'd6
    };

endpackage

// ===== hdl/stsc_front.sv =====
// front end: position counting, scan state machine and token capture
// depends on stsc_pkg; feeds stsc_queue with one entry per transfer that yields tokens
module stsc_front
    import stsc_pkg::*;
#(
    parameter int MAX_LEN       = DEFAULT_MAX_LEN,
    parameter int POSITION_BITS = DEFAULT_POSITION_BITS
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  logic [7:0] in_char,
    input  logic   in_end,
    input  logic   q_full,
    output logic   push,
    output entry_t push_entry
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);

    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_DQUOTE = 8'd34;
    localparam logic [7:0] CH_HASH   = 8'd35;
    localparam logic [7:0] CH_DOLLAR = 8'd36;
    localparam logic [7:0] CH_SQUOTE = 8'd39;
    localparam logic [7:0] CH_STAR   = 8'd42;
    localparam logic [7:0] CH_SLASH  = 8'd47;
    localparam logic [7:0] CH_UNDER  = 8'd95;

    mode_t                    mode_reg, mode_next;
    logic                     quote_single_reg, quote_single_next;
    logic [POSITION_BITS-1:0] line_reg, line_next;
    logic [POSITION_BITS-1:0] col_reg, col_next;
    logic [POSITION_BITS-1:0] tline_reg, tline_next;
    logic [POSITION_BITS-1:0] tcol_reg, tcol_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     ovf_reg, ovf_next;
    logic [63:0]              prefix_reg, prefix_next;
    logic [7:0]               first_reg, first_next;

    logic accept;

    function automatic logic [15:0] pos_out(input logic [POSITION_BITS-1:0] x);
        logic [POSITION_BITS+15:0] e;
        e = {16'b0, x};
        return e[15:0];
    endfunction

    function automatic tok_t make_tok(input kind_t kind,
                                      input logic [POSITION_BITS-1:0] line,
                                      input logic [POSITION_BITS-1:0] col,
                                      input logic [CNT_W-1:0] cnt,
                                      input logic ovf,
                                      input logic [7:0] first,
                                      input logic closed,
                                      input logic [63:0] prefix);
        tok_t t;
        logic [CNT_W+7:0] e;
        e          = {8'b0, cnt};
        t.kind     = kind;
        t.line     = pos_out(line);
        t.column   = pos_out(col);
        t.length   = e[7:0];
        t.word_len = (!ovf && cnt <= CNT_W'(8)) ? e[3:0] : 4'd0;
        t.overflow = ovf;
        t.first    = first;
        t.closed   = closed;
        t.prefix   = prefix;
        return t;
    endfunction

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        logic [POSITION_BITS-1:0] line_pos, col_pos;
        logic             is_space, is_digit, is_alpha, id_start, id_more;
        mode_t            idle_mode;
        logic             idle_start, idle_special, go_idle;
        logic             emit0;
        tok_t             tok0, tok_special, tok_end;
        logic [CNT_W-1:0] add_cnt;
        logic             add_ovf;
        logic [63:0]      add_prefix;
        logic             closing;

        mode_next         = mode_reg;
        quote_single_next = quote_single_reg;
        line_next         = line_reg;
        col_next          = col_reg;
        tline_next        = tline_reg;
        tcol_next         = tcol_reg;
        cnt_next          = cnt_reg;
        ovf_next          = ovf_reg;
        prefix_next       = prefix_reg;
        first_next        = first_reg;
        push              = 1'b0;
        push_entry        = '0;
        emit0             = 1'b0;
        go_idle           = 1'b0;
        tok0              = '0;

        // position of this character, counted before it is looked at
        line_pos = line_reg;
        col_pos  = col_reg;
        if (in_char == CH_LF)
        begin
            if (line_reg != '1)
                line_pos = line_reg + 1'b1;
            col_pos = '0;
        end
        else if (col_reg != '1)
        begin
            col_pos = col_reg + 1'b1;
        end

        is_space = (in_char == CH_SPACE) || (in_char >= 8'd9 && in_char <= 8'd13);
        is_digit = (in_char >= 8'd48 && in_char <= 8'd57);
        is_alpha = (in_char >= 8'd65 && in_char <= 8'd90) ||
                   (in_char >= 8'd97 && in_char <= 8'd122);
        id_start = is_alpha || in_char == CH_UNDER || in_char == CH_DOLLAR;
        id_more  = id_start || is_digit;

        // what a character does when seen outside any token
        idle_start   = 1'b0;
        idle_special = 1'b0;
        idle_mode    = MODE_IDLE;
        if (is_space)
            idle_mode = MODE_IDLE;
        else if (in_char == CH_HASH && col_pos == POSITION_BITS'(1))
            idle_mode = MODE_LINE;
        else if (in_char == CH_SLASH)
        begin
            idle_mode  = MODE_SLASH;
            idle_start = 1'b1;
        end
        else if (in_char == CH_DQUOTE || in_char == CH_SQUOTE)
        begin
            idle_mode  = MODE_STRING;
            idle_start = 1'b1;
        end
        else if (is_digit)
        begin
            idle_mode  = MODE_NUMBER;
            idle_start = 1'b1;
        end
        else if (id_start)
        begin
            idle_mode  = MODE_IDENT;
            idle_start = 1'b1;
        end
        else
            idle_special = 1'b1;

        // append the character to the open token
        add_cnt    = (cnt_reg < CNT_W'(MAX_LEN)) ? cnt_reg + 1'b1 : cnt_reg;
        add_ovf    = (cnt_reg >= CNT_W'(MAX_LEN)) ? 1'b1 : ovf_reg;
        add_prefix = prefix_reg;
        if (mode_reg == MODE_IDENT)
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (cnt_reg == CNT_W'(i))
                    add_prefix[8*i +: 8] = in_char;
            end
        end

        closing = (in_char == (quote_single_reg ? CH_SQUOTE : CH_DQUOTE));

        tok_special = make_tok(KIND_SPECIAL, line_pos, col_pos, CNT_W'(1), 1'b0, in_char,
                               1'b0, 64'd0);
        tok_end     = make_tok(KIND_END, line_reg, col_reg, '0, 1'b0, 8'd0, 1'b0, 64'd0);

        if (in_end)
        begin
            // flush an open token, then the end token, then back to reset values
            unique case (mode_reg)
                MODE_IDENT:
                begin
                    emit0 = 1'b1;
                    tok0  = make_tok(KIND_IDENT, tline_reg, tcol_reg, cnt_reg, ovf_reg,
                                     first_reg, 1'b0, prefix_reg);
                end
                MODE_NUMBER:
                begin
                    emit0 = 1'b1;
                    tok0  = make_tok(KIND_NUMBER, tline_reg, tcol_reg, cnt_reg, ovf_reg,
                                     first_reg, 1'b0, 64'd0);
                end
                MODE_STRING:
                begin
                    emit0 = 1'b1;
                    tok0  = make_tok(KIND_STRING, tline_reg, tcol_reg, cnt_reg, ovf_reg,
                                     first_reg, 1'b0, 64'd0);
                end
                MODE_SLASH:
                begin
                    emit0 = 1'b1;
                    tok0  = make_tok(KIND_SPECIAL, tline_reg, tcol_reg, cnt_reg, ovf_reg,
                                     first_reg, 1'b0, 64'd0);
                end
                default:
                    emit0 = 1'b0;
            endcase
            push = accept;
            if (emit0)
            begin
                push_entry.first_tok    = tok0;
                push_entry.second       = tok_end;
                push_entry.second_valid = 1'b1;
            end
            else
            begin
                push_entry.first_tok    = tok_end;
                push_entry.second_valid = 1'b0;
            end
            mode_next         = MODE_IDLE;
            quote_single_next = 1'b0;
            line_next         = POSITION_BITS'(1);
            col_next          = '0;
            tline_next        = POSITION_BITS'(1);
            tcol_next         = '0;
            cnt_next          = '0;
            ovf_next          = 1'b0;
            prefix_next       = '0;
            first_next        = 8'd0;
        end
        else
        begin
            line_next = line_pos;
            col_next  = col_pos;
            unique case (mode_reg)
                MODE_IDENT:
                begin
                    if (id_more)
                    begin
                        cnt_next    = add_cnt;
                        ovf_next    = add_ovf;
                        prefix_next = add_prefix;
                    end
                    else
                    begin
                        emit0   = 1'b1;
                        tok0    = make_tok(KIND_IDENT, tline_reg, tcol_reg, cnt_reg, ovf_reg,
                                           first_reg, 1'b0, prefix_reg);
                        go_idle = 1'b1;
                    end
                end
                MODE_NUMBER:
                begin
                    if (is_digit)
                    begin
                        cnt_next = add_cnt;
                        ovf_next = add_ovf;
                    end
                    else
                    begin
                        emit0   = 1'b1;
                        tok0    = make_tok(KIND_NUMBER, tline_reg, tcol_reg, cnt_reg, ovf_reg,
                                           first_reg, 1'b0, 64'd0);
                        go_idle = 1'b1;
                    end
                end
                MODE_STRING:
                begin
                    cnt_next = add_cnt;
                    ovf_next = add_ovf;
                    if (closing)
                    begin
                        emit0     = 1'b1;
                        tok0      = make_tok(KIND_STRING, tline_reg, tcol_reg, add_cnt, add_ovf,
                                             first_reg, 1'b1, 64'd0);
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_SLASH:
                begin
                    if (in_char == CH_SLASH)
                        mode_next = MODE_LINE;
                    else if (in_char == CH_STAR)
                        mode_next = MODE_BLOCK;
                    else
                    begin
                        emit0   = 1'b1;
                        tok0    = make_tok(KIND_SPECIAL, tline_reg, tcol_reg, cnt_reg, ovf_reg,
                                           first_reg, 1'b0, 64'd0);
                        go_idle = 1'b1;
                    end
                end
                MODE_LINE:
                begin
                    if (in_char == CH_LF)
                        mode_next = MODE_IDLE;
                end
                MODE_BLOCK:
                begin
                    if (in_char == CH_STAR)
                        mode_next = MODE_STAR;
                end
                MODE_STAR:
                begin
                    if (in_char == CH_SLASH)
                        mode_next = MODE_IDLE;
                    else if (in_char != CH_STAR)
                        mode_next = MODE_BLOCK;
                end
                MODE_IDLE:
                    go_idle = 1'b1;
                default:
                    mode_next = MODE_IDLE;
            endcase

            if (go_idle)
            begin
                mode_next = idle_mode;
                if (idle_start)
                begin
                    tline_next  = line_pos;
                    tcol_next   = col_pos;
                    cnt_next    = CNT_W'(1);
                    ovf_next    = 1'b0;
                    first_next  = in_char;
                    prefix_next = (idle_mode == MODE_IDENT) ? {56'd0, in_char} : 64'd0;
                    if (idle_mode == MODE_STRING)
                        quote_single_next = (in_char == CH_SQUOTE);
                end
            end

            if (emit0)
            begin
                push                    = accept;
                push_entry.first_tok    = tok0;
                push_entry.second       = tok_special;
                push_entry.second_valid = go_idle && idle_special;
            end
            else if (go_idle && idle_special)
            begin
                push                    = accept;
                push_entry.first_tok    = tok_special;
                push_entry.second_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_IDLE;
        else if (accept)
            mode_reg <= mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quote_single_reg <= 1'b0;
            line_reg         <= POSITION_BITS'(1);
            col_reg          <= '0;
            tline_reg        <= POSITION_BITS'(1);
            tcol_reg         <= '0;
            cnt_reg          <= '0;
            ovf_reg          <= 1'b0;
            prefix_reg       <= '0;
            first_reg        <= 8'd0;
        end
        else if (accept)
        begin
            quote_single_reg <= quote_single_next;
            line_reg         <= line_next;
            col_reg          <= col_next;
            tline_reg        <= tline_next;
            tcol_reg         <= tcol_next;
            cnt_reg          <= cnt_next;
            ovf_reg          <= ovf_next;
            prefix_reg       <= prefix_next;
            first_reg        <= first_next;
        end
    end

endmodule

// ===== hdl/stsc_queue.sv =====
// short register queue of token entries between front and back end
// depends on stsc_pkg and the scanner assertion macro header
`include "script_token_scanner_core_defines.svh"

module stsc_queue
    import stsc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output entry_t head,
    output logic   empty,
    output logic   full
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    entry_t           slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign head  = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // front must hold off while the queue is full, back never pops an empty queue
    `STSC_ASSERT_IMP(a_no_push_full, clk, rst_n, push, !full)
    `STSC_ASSERT_IMP(a_no_pop_empty, clk, rst_n, pop, !empty)
    `STSC_ASSERT_NXT(a_fill_tracks, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

// ===== hdl/stsc_back.sv =====
// back end: keyword match, splitting an entry into transfers, output register
// depends on stsc_pkg; drains stsc_queue
module stsc_back
    import stsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  entry_t      head,
    input  logic        empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [55:0] out_data,
    output logic [2:0]  out_user,
    output logic        out_last
);

    logic        phase_reg, phase_next;
    logic        valid_reg, valid_next;
    kind_t       kind_reg, kind_next;
    logic [3:0]  kw_reg, kw_next;
    logic [15:0] line_reg, line_next;
    logic [15:0] col_reg, col_next;
    logic [7:0]  len_reg, len_next;
    logic        ovf_reg, ovf_next;
    logic [7:0]  first_reg, first_next;
    logic        closed_reg, closed_next;
    logic        last_reg, last_next;

    always_comb
    begin
        tok_t cur;
        logic cur_last;
        logic load;

        cur      = phase_reg ? head.second : head.first_tok;
        cur_last = phase_reg || !head.second_valid;
        load     = !empty && (!valid_reg || out_ready);

        phase_next  = phase_reg;
        valid_next  = valid_reg;
        kind_next   = kind_reg;
        kw_next     = kw_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        len_next    = len_reg;
        ovf_next    = ovf_reg;
        first_next  = first_reg;
        closed_next = closed_reg;
        last_next   = last_reg;
        pop         = 1'b0;

        if (out_ready)
            valid_next = 1'b0;

        if (load)
        begin
            valid_next  = 1'b1;
            kind_next   = cur.kind;
            kw_next     = 4'd0;
            line_next   = cur.line;
            col_next    = cur.column;
            len_next    = cur.length;
            ovf_next    = cur.overflow;
            first_next  = cur.first;
            closed_next = cur.closed;
            last_next   = cur_last;
            // identifiers that spell a keyword become keywords
            if (cur.kind == KIND_IDENT)
            begin
                for (int i = KW_COUNT - 1; i >= 0; i--)
                begin
                    if (cur.word_len == KW_LEN[i] && cur.prefix == KW_TEXT[i])
                    begin
                        kind_next = KIND_KEYWORD;
                        kw_next   = 4'(i);
                    end
                end
            end
            pop        = cur_last;
            phase_next = !cur_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        kw_reg     <= kw_next;
        line_reg   <= line_next;
        col_reg    <= col_next;
        len_reg    <= len_next;
        ovf_reg    <= ovf_next;
        first_reg  <= first_next;
        closed_reg <= closed_next;
        last_reg   <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_user  = kind_reg;
    assign out_last  = last_reg;
    assign out_data  = {2'b00, closed_reg, first_reg, ovf_reg, len_reg, col_reg, line_reg,
                        kw_reg};

endmodule

// ===== hdl/script_token_scanner_core.sv =====
// top level of the script token scanner: front end, entry queue, back end
// depends on stsc_pkg, stsc_front, stsc_queue and stsc_back
//
//  channel    direction  fields
//  s_axis     in         tdata: char_byte; tlast: end_of_input
//  m_axis     out        tdata: token descriptor; tuser: token_kind; tlast: last_of_run
//
// one source byte is taken every cycle while the entry queue has room
// each token leaves in one transfer; a byte that yields two tokens needs two output transfers
// the four-entry queue lets the front keep taking bytes while the back is stalled, until the queue is full
// rst_n clears the scan state, the queue fill and the output valid flag at once
// output data is registered; s_axis_tready depends only on the queue fill
module script_token_scanner_core
    import stsc_pkg::*;
#(
    parameter int MAX_LEN       = DEFAULT_MAX_LEN,
    parameter int POSITION_BITS = DEFAULT_POSITION_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  logic        s_axis_tlast,   // end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] keyword_index, [19:4] start_line, [35:20] start_column,
    // [43:36] token_length, [44] length_overflow, [52:45] first_byte,
    // [53] string_closed, [55:54] zero
    output logic [55:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,   // [2:0] token_kind
    output logic        m_axis_tlast    // last_of_run
);

    // entry of up to two tokens per input transfer
    logic   q_push;
    entry_t q_push_entry;
    logic   q_pop;
    entry_t q_head;
    logic   q_empty;
    logic   q_full;

    // byte classification, position counters and token capture
    stsc_front #(
        .MAX_LEN       (MAX_LEN),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_char    (s_axis_tdata),
        .in_end     (s_axis_tlast),
        .q_full     (q_full),
        .push       (q_push),
        .push_entry (q_push_entry)
    );

    // decouples the byte side from the token side
    stsc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty),
        .full       (q_full)
    );

    // keyword match and one transfer per token
    stsc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for script_token_scanner_core: byte stream in, token descriptors out
// depends on stsc_pkg for the token kind and scan mode types; predicts every token on its own
module testbench
    import stsc_pkg::*;
;

    localparam int TOKEN_MAX     = DEFAULT_MAX_LEN;
    localparam int KEYWORD_COUNT = 9;
    localparam int RANDOM_ITEMS  = 200;
    localparam int SETTLE_CYCLES = 24;

    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [3:0] NO_KEYWORD = 4'd0;
    localparam logic [15:0] POS_LIMIT = 16'hFFFF;

    typedef struct {
        kind_t       kind;
        logic [3:0]  keyword;
        logic [15:0] line;
        logic [15:0] column;
        logic [7:0]  length;
        logic        overflow;
        logic [7:0]  first;
        logic        closed;
        logic        last;
    } token_desc_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // tokens still owed by the block, oldest first
    token_desc_t expected_tokens [$];
    int          error_count     = 0;
    int          items_sent      = 0;
    int          sink_stall_left = 0;
    bit          steady_flow     = 1'b0;

    string keyword_words [KEYWORD_COUNT] = '{
        "function", "var", "let", "const", "if", "else", "for", "while", "return"
    };
    string special_chars = "(){}[];,.+-*=<>!&|?:%^~@\\";
    string comment_fill  = "**//ab \n";

    // scanner state as the predictor sees it
    mode_t       lex_mode;
    logic        lex_single;
    logic [15:0] lex_line;
    logic [15:0] lex_col;
    logic [15:0] lex_tok_line;
    logic [15:0] lex_tok_col;
    logic [7:0]  lex_count;
    logic        lex_ovf;
    logic [63:0] lex_prefix;
    logic [7:0]  lex_first;

    script_token_scanner_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // generous cap, far beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_digit_char(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_word_start(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == CH_UNDER
            || c == CH_DOLLAR;
    endfunction

    function automatic bit is_word_char(logic [7:0] c);
        return is_word_start(c) || is_digit_char(c);
    endfunction

    function automatic void lex_clear();
        lex_mode     = MODE_IDLE;
        lex_single   = 1'b0;
        lex_line     = 16'd1;
        lex_col      = 16'd0;
        lex_tok_line = 16'd1;
        lex_tok_col  = 16'd0;
        lex_count    = 8'd0;
        lex_ovf      = 1'b0;
        lex_prefix   = 64'd0;
        lex_first    = 8'd0;
    endfunction

    function automatic void note_token(kind_t kind, logic [3:0] keyword, logic [15:0] line,
                                       logic [15:0] column, logic [7:0] length,
                                       logic overflow, logic [7:0] first, logic closed);
        token_desc_t t;
        t.kind     = kind;
        t.keyword  = keyword;
        t.line     = line;
        t.column   = column;
        t.length   = length;
        t.overflow = overflow;
        t.first    = first;
        t.closed   = closed;
        t.last     = 1'b0;
        expected_tokens.push_back(t);
    endfunction

    function automatic void lex_start(mode_t mode, logic [7:0] c);
        lex_mode     = mode;
        lex_tok_line = lex_line;
        lex_tok_col  = lex_col;
        lex_count    = 8'd1;
        lex_ovf      = 1'b0;
        lex_first    = c;
        lex_prefix   = (mode == MODE_IDENT) ? {56'd0, c} : 64'd0;
    endfunction

    function automatic void lex_add(logic [7:0] c);
        if (lex_mode == MODE_IDENT && lex_count < 8)
            lex_prefix[8 * lex_count +: 8] = c;
        if (lex_count < TOKEN_MAX)
            lex_count = lex_count + 8'd1;
        else
            lex_ovf = 1'b1;
    endfunction

    function automatic void lex_emit_open(kind_t kind, logic [3:0] keyword, logic closed);
        note_token(kind, keyword, lex_tok_line, lex_tok_col, lex_count, lex_ovf, lex_first,
                   closed);
    endfunction

    // an identifier becomes a keyword only on an exact, non-overflowed spelling
    function automatic void lex_emit_word();
        bit same;
        if (!lex_ovf)
        begin
            for (int k = 0; k < KEYWORD_COUNT; k++)
            begin
                same = (keyword_words[k].len() == lex_count);
                for (int j = 0; same && j < keyword_words[k].len(); j++)
                    if (keyword_words[k][j] != lex_prefix[8 * j +: 8])
                        same = 1'b0;
                if (same)
                begin
                    lex_emit_open(KIND_KEYWORD, 4'(k), 1'b0);
                    return;
                end
            end
        end
        lex_emit_open(KIND_IDENT, NO_KEYWORD, 1'b0);
    endfunction

    function automatic void lex_idle(logic [7:0] c);
        lex_mode = MODE_IDLE;
        if (is_blank(c))
            return;
        if (c == CH_HASH && lex_col == 16'd1)
            lex_mode = MODE_LINE;
        else if (c == CH_SLASH)
            lex_start(MODE_SLASH, c);
        else if (c == CH_DQUOTE || c == CH_SQUOTE)
        begin
            lex_start(MODE_STRING, c);
            lex_single = (c == CH_SQUOTE);
        end
        else if (is_digit_char(c))
            lex_start(MODE_NUMBER, c);
        else if (is_word_start(c))
            lex_start(MODE_IDENT, c);
        else
            note_token(KIND_SPECIAL, NO_KEYWORD, lex_line, lex_col, 8'd1, 1'b0, c, 1'b0);
    endfunction

    // works out every token that one accepted transfer causes
    function automatic void predict_tokens(logic [7:0] c, logic eoi);
        int owed_prior;
        owed_prior = expected_tokens.size();
        if (eoi)
        begin
            case (lex_mode)
                MODE_IDENT:  lex_emit_word();
                MODE_NUMBER: lex_emit_open(KIND_NUMBER, NO_KEYWORD, 1'b0);
                MODE_STRING: lex_emit_open(KIND_STRING, NO_KEYWORD, 1'b0);
                MODE_SLASH:  lex_emit_open(KIND_SPECIAL, NO_KEYWORD, 1'b0);
                default:     ;
            endcase
            note_token(KIND_END, NO_KEYWORD, lex_line, lex_col, 8'd0, 1'b0, 8'd0, 1'b0);
            lex_clear();
        end
        else
        begin
            // position moves before the byte is classified
            if (c == CH_NEWLINE)
            begin
                if (lex_line != POS_LIMIT)
                    lex_line = lex_line + 16'd1;
                lex_col = 16'd0;
            end
            else if (lex_col != POS_LIMIT)
                lex_col = lex_col + 16'd1;

            case (lex_mode)
                MODE_IDENT:
                    if (is_word_char(c))
                        lex_add(c);
                    else
                    begin
                        lex_emit_word();
                        lex_idle(c);
                    end
                MODE_NUMBER:
                    if (is_digit_char(c))
                        lex_add(c);
                    else
                    begin
                        lex_emit_open(KIND_NUMBER, NO_KEYWORD, 1'b0);
                        lex_idle(c);
                    end
                MODE_STRING:
                begin
                    lex_add(c);
                    if (c == (lex_single ? CH_SQUOTE : CH_DQUOTE))
                    begin
                        lex_emit_open(KIND_STRING, NO_KEYWORD, 1'b1);
                        lex_mode = MODE_IDLE;
                    end
                end
                MODE_SLASH:
                    if (c == CH_SLASH)
                        lex_mode = MODE_LINE;
                    else if (c == CH_STAR)
                        lex_mode = MODE_BLOCK;
                    else
                    begin
                        lex_emit_open(KIND_SPECIAL, NO_KEYWORD, 1'b0);
                        lex_idle(c);
                    end
                MODE_LINE:
                    if (c == CH_NEWLINE)
                        lex_mode = MODE_IDLE;
                MODE_BLOCK:
                    if (c == CH_STAR)
                        lex_mode = MODE_STAR;
                MODE_STAR:
                    if (c == CH_SLASH)
                        lex_mode = MODE_IDLE;
                    else if (c != CH_STAR)
                        lex_mode = MODE_BLOCK;
                default:
                    lex_idle(c);
            endcase
        end
        if (expected_tokens.size() > owed_prior)
            expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        error_count++;
        $display("mismatch at %0t, %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic compare_field(string what, longint unsigned got, longint unsigned want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    task automatic check_token();
        token_desc_t want;
        if (expected_tokens.size() == 0)
        begin
            report_mismatch("token with nothing expected", m_axis_tdata, 0);
            return;
        end
        want = expected_tokens.pop_front();
        compare_field("token_kind", m_axis_tuser, want.kind);
        compare_field("keyword_index", m_axis_tdata[3:0], want.keyword);
        compare_field("start_line", m_axis_tdata[19:4], want.line);
        compare_field("start_column", m_axis_tdata[35:20], want.column);
        compare_field("token_length", m_axis_tdata[43:36], want.length);
        compare_field("length_overflow", m_axis_tdata[44], want.overflow);
        compare_field("first_byte", m_axis_tdata[52:45], want.first);
        compare_field("string_closed", m_axis_tdata[53], want.closed);
        compare_field("last_of_run", m_axis_tlast, want.last);
    endtask

    // outputs sampled at the edge, before the block updates them
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_token();
    end

    // ---------------------------------------------------------------- idling

    // mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        if (steady_flow)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // token sink with random back-pressure
    always @(posedge clk)
    begin
        int stall;
        if (sink_stall_left > 0 && !steady_flow)
        begin
            sink_stall_left <= sink_stall_left - 1;
            m_axis_tready   <= 1'b0;
        end
        else
        begin
            stall = pick_gap();
            sink_stall_left <= (stall > 0) ? stall - 1 : 0;
            m_axis_tready   <= (stall == 0);
        end
    end

    // ---------------------------------------------------------------- stimulus

    // one byte transfer; valid stays high into the next call when no gap follows
    task automatic send_item(input logic [7:0] ch, input logic eoi);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= eoi;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        predict_tokens(ch, eoi);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    task automatic send_repeat(input logic [7:0] ch, input int count);
        repeat (count) send_item(ch, 1'b0);
    endtask

    // the byte beside an end mark is ignored, so it is left random
    task automatic send_end();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // hold the sender until every owed token has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] word_char(bit leading);
        int roll;
        roll = $urandom_range(0, 63);
        if (roll < 26)
            return 8'("a" + roll);
        if (roll < 52)
            return 8'("A" + roll - 26);
        if (roll < 56)
            return CH_UNDER;
        if (roll < 58 || leading)
            return CH_DOLLAR;
        return CH_ZERO + 8'(roll - 58);
    endfunction

    // mostly well-formed lexemes with random content, plus comments, noise and end marks
    task automatic send_random_token();
        int         pick;
        logic [7:0] quote;
        logic [7:0] ch;
        pick = $urandom_range(0, 39);
        if (pick < 6)
            send_text(keyword_words[$urandom_range(0, KEYWORD_COUNT - 1)]);
        else if (pick < 12)
        begin
            send_item(word_char(1'b1), 1'b0);
            repeat ($urandom_range(0, 9)) send_item(word_char(1'b0), 1'b0);
        end
        else if (pick < 16)
            repeat ($urandom_range(1, 6)) send_item(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
        else if (pick < 19)
        begin
            quote = ($urandom_range(0, 1) != 0) ? CH_SQUOTE : CH_DQUOTE;
            send_item(quote, 1'b0);
            repeat ($urandom_range(0, 8))
            begin
                ch = ($urandom_range(0, 9) == 0) ? CH_NEWLINE : 8'($urandom_range(32, 126));
                if (ch == quote)
                    ch = "x";
                send_item(ch, 1'b0);
            end
            // now and then the string is left open
            if ($urandom_range(0, 9) != 0)
                send_item(quote, 1'b0);
        end
        else if (pick < 25)
            send_item(special_chars[$urandom_range(0, special_chars.len() - 1)], 1'b0);
        else if (pick < 30)
            repeat ($urandom_range(1, 3))
                send_item(($urandom_range(0, 3) == 0) ? CH_NEWLINE
                          : (($urandom_range(0, 1) != 0) ? CH_SPACE
                             : 8'($urandom_range(9, 13))), 1'b0);
        else if (pick < 32)
        begin
            send_text("//");
            repeat ($urandom_range(0, 6))
            begin
                ch = 8'($urandom_range(0, 255));
                send_item((ch == CH_NEWLINE) ? 8'("c") : ch, 1'b0);
            end
            send_item(CH_NEWLINE, 1'b0);
        end
        else if (pick < 34)
        begin
            send_text("/*");
            repeat ($urandom_range(0, 6))
                send_item(comment_fill[$urandom_range(0, comment_fill.len() - 1)], 1'b0);
            send_text("*/");
        end
        else if (pick < 35)
        begin
            // hash at the start of a line hides the whole line
            send_item(CH_NEWLINE, 1'b0);
            send_item(CH_HASH, 1'b0);
            repeat ($urandom_range(0, 5)) send_item(8'($urandom_range(32, 126)), 1'b0);
            send_item(CH_NEWLINE, 1'b0);
        end
        else if (pick < 37)
            send_item(CH_SLASH, 1'b0);
        else if (pick < 39)
            send_item(8'($urandom_range(0, 255)), 1'b0);
        else
            send_end();
    endtask

    // ---------------------------------------------------------------- tests

    // hash line, keyword, specials, block comment closed by "/*/*/", number ended by
    // a slash, line comment, extreme bytes, open string and open tokens flushed at end
    task automatic test_directed_text();
        send_text("#!x\nif(a1) #/*/*/9//c\n\011\013\014\015 ");
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_text("'o");
        send_end();
        send_text("x/");
        send_end();
        send_text("\"a\nb\" 7");
        send_end();
        send_text("/*x");
        send_end();
    endtask

    // length at the limit, just over it with keyword text inside, and an overlong string
    task automatic test_long_tokens();
        send_item(word_char(1'b1), 1'b0);
        repeat (TOKEN_MAX - 1) send_item(word_char(1'b0), 1'b0);
        send_item(CH_SPACE, 1'b0);
        send_text("function");
        send_repeat("q", TOKEN_MAX - 7);
        send_text(";");
        send_item(CH_DQUOTE, 1'b0);
        send_repeat("s", TOKEN_MAX);
        send_item(CH_DQUOTE, 1'b0);
        send_end();
    endtask

    task automatic test_random_source();
        int first;
        bit paused;
        first  = items_sent;
        paused = 1'b0;
        while (items_sent - first < RANDOM_ITEMS)
        begin
            // stretches with no idling on either side
            if ($urandom_range(0, 29) == 0)
                steady_flow = !steady_flow;
            if (!paused && items_sent - first >= RANDOM_ITEMS / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
            send_random_token();
        end
        steady_flow = 1'b0;
        send_end();
    endtask

    initial
    begin
        lex_clear();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_text();
        drain_results();
        test_long_tokens();
        drain_results();
        test_random_source();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_tokens.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== script_token_scanner_core.f =====
+incdir+hdl
hdl/stsc_pkg.sv
hdl/stsc_front.sv
hdl/stsc_queue.sv
hdl/stsc_back.sv
hdl/script_token_scanner_core.sv
tb/testbench.sv
